/* src/skt_pkg.sv */
// Shared widths, codes and the record type of the sorted key table.
package skt_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int KEY_W = 64;
	localparam int BOUND_W = 32;
	localparam int TICK_W = 64;
	localparam int CAP_W = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_GET = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [BOUND_W-1:0] lo;
		logic [BOUND_W-1:0] hi;
		logic [TICK_W-1:0]  tick;
	} rec_t;

endpackage

/* src/skt_if.sv */
// Channel interfaces of the sorted key table: request, response and configuration.
interface skt_req_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [skt_pkg::KEY_W-1:0]   cohort_key;
	logic [skt_pkg::BOUND_W-1:0] lower_bound;
	logic [skt_pkg::BOUND_W-1:0] upper_bound;
	logic [skt_pkg::TICK_W-1:0]  tick;

	modport source (output valid, kind, cohort_key, lower_bound, upper_bound, tick,
		input ready);
	modport sink (input valid, kind, cohort_key, lower_bound, upper_bound, tick,
		output ready);
endinterface

interface skt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic                        known;
	logic [skt_pkg::KEY_W-1:0]   key_out;
	logic [skt_pkg::BOUND_W-1:0] min_out;
	logic [skt_pkg::BOUND_W-1:0] max_out;
	logic [skt_pkg::TICK_W-1:0]  tick_out;

	modport source (output valid, status, known, key_out, min_out, max_out, tick_out,
		input ready);
	modport sink (input valid, status, known, key_out, min_out, max_out, tick_out,
		output ready);
endinterface

interface skt_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [skt_pkg::CAP_W-1:0] capacity_limit;

	modport source (output valid, capacity_limit, input ready);
	modport sink (input valid, capacity_limit, output ready);
endinterface

/* src/sorted_key_table_insert_lookup.sv */
// Sorted key table with insert/update and lookup over one two-port record memory.
//
//   channel | role         | payload
//   --------+--------------+-----------------------------------------------------
//   req     | item in      | kind, cohort_key, lower_bound, upper_bound, tick
//   rsp     | result out   | status, known, key_out, min_out, max_out, tick_out
//   cfg     | register in  | capacity_limit
//
// An item searches the records in order, S being the records visited (at most TABLE_DEPTH + 1),
// and its result is then registered. A new key also moves the M records above it up one slot
// and is written into the freed slot; S + M is then at most TABLE_DEPTH.
// Reset clears the state, the record count and the output valid; the limit returns to 64
// and the record memory is not cleared. A stalled response holds its register while the
// next transaction is accepted and searched; that item then waits in its last state.
module sorted_key_table_insert_lookup #(
	parameter int TABLE_DEPTH = skt_pkg::DEPTH_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp,
	skt_cfg_if.sink   cfg
);

	// Index width holds 0..TABLE_DEPTH; address width covers the slots only.
	localparam int IW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CMPW = (IW > skt_pkg::CAP_W) ? IW : skt_pkg::CAP_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_PREP   = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	// The record memory: one write and one registered read each cycle.
	skt_pkg::rec_t mem [TABLE_DEPTH];
	skt_pkg::rec_t rdata_q;

	logic [2:0]    state_q;
	logic [IW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] j_q;
	logic [skt_pkg::CAP_W-1:0] cap_q;

	// The item being worked on.
	logic                          kind_q;
	logic [skt_pkg::KEY_W-1:0]     key_q;
	logic [skt_pkg::BOUND_W-1:0]   lo_q;
	logic [skt_pkg::BOUND_W-1:0]   hi_q;
	logic [skt_pkg::TICK_W-1:0]    tick_q;

	// Result waiting for the output register.
	logic                          pend_status_q;
	logic                          pend_known_q;
	logic [skt_pkg::BOUND_W-1:0]   pend_min_q;
	logic [skt_pkg::BOUND_W-1:0]   pend_max_q;
	logic [skt_pkg::TICK_W-1:0]    pend_tick_q;

	// Output register.
	logic                          out_vld_q;
	logic                          out_status_q;
	logic                          out_known_q;
	logic [skt_pkg::KEY_W-1:0]     out_key_q;
	logic [skt_pkg::BOUND_W-1:0]   out_min_q;
	logic [skt_pkg::BOUND_W-1:0]   out_max_q;
	logic [skt_pkg::TICK_W-1:0]    out_tick_q;

	logic          in_range;
	logic          key_eq;
	logic          key_gt;
	logic          hit;
	logic          search_end;
	logic          table_full;
	logic          load_out;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	skt_pkg::rec_t wr_data;
	skt_pkg::rec_t new_rec;
	logic [IW-1:0] rd_idx;
	logic [AW-1:0] rd_addr;

	// In the search, rdata_q always holds the record at idx_q.
	assign in_range   = (idx_q < count_q);
	assign key_eq     = (rdata_q.key == key_q);
	assign key_gt     = (rdata_q.key > key_q);
	assign hit        = in_range && key_eq;
	assign search_end = !in_range || key_eq || key_gt;

	// New keys are refused at the smaller of the register and the built depth.
	assign table_full = (CMPW'(count_q) >= CMPW'(cap_q)) ||
		(count_q == IW'(TABLE_DEPTH));

	assign load_out = (state_q == S_DONE) && (!out_vld_q || rsp.ready);

	// An upper bound below the lower bound is raised to it before storing.
	always_comb begin
		new_rec.key  = key_q;
		new_rec.lo   = lo_q;
		new_rec.hi   = (hi_q < lo_q) ? lo_q : hi_q;
		new_rec.tick = tick_q;
	end

	// Write port: an update in place at the end of the search, or the move-up walk
	// that ends with the new record written into the freed slot.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = new_rec;
		unique case (state_q)
			S_SEARCH: begin
				wr_en = search_end && hit && (kind_q == skt_pkg::KIND_REPORT);
			end
			S_SHIFT: begin
				wr_en = 1'b1;
				if (j_q != idx_q) begin
					wr_addr = j_q[AW-1:0];
					wr_data = rdata_q;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Read port: the search reads ahead one slot; the move-up walk reads one slot below
	// the slot it writes. Indexes past the end read slot 0 and the data goes unused.
	always_comb begin
		unique case (state_q)
			S_SEARCH: rd_idx = idx_q + IW'(1);
			S_PREP:   rd_idx = j_q - IW'(1);
			S_SHIFT:  rd_idx = j_q - IW'(2);
			default:  rd_idx = '0;
		endcase
		rd_addr = (rd_idx < IW'(TABLE_DEPTH)) ? rd_idx[AW-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			j_q       <= '0;
			cap_q     <= skt_pkg::CAP_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.capacity_limit;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q   <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (!search_end) begin
						idx_q <= idx_q + IW'(1);
					end else if (kind_q == skt_pkg::KIND_GET || hit || table_full) begin
						state_q <= S_DONE;
					end else begin
						j_q     <= count_q;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (j_q == idx_q) begin
						count_q <= count_q + IW'(1);
						state_q <= S_DONE;
					end else begin
						j_q <= j_q - IW'(1);
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			kind_q <= req.kind;
			key_q  <= req.cohort_key;
			lo_q   <= req.lower_bound;
			hi_q   <= req.upper_bound;
			tick_q <= req.tick;
		end

		if (state_q == S_SEARCH && search_end) begin
			pend_status_q <= (kind_q == skt_pkg::KIND_REPORT) && !hit && table_full ?
				skt_pkg::STATUS_FULL : skt_pkg::STATUS_OK;
			pend_known_q  <= (kind_q == skt_pkg::KIND_GET) && hit;
			if (kind_q == skt_pkg::KIND_GET && hit) begin
				pend_min_q  <= rdata_q.lo;
				pend_max_q  <= rdata_q.hi;
				pend_tick_q <= rdata_q.tick;
			end else begin
				pend_min_q  <= '0;
				pend_max_q  <= '0;
				pend_tick_q <= (kind_q == skt_pkg::KIND_GET) ? '1 : '0;
			end
		end

		if (load_out) begin
			out_status_q <= pend_status_q;
			out_known_q  <= pend_known_q;
			out_key_q    <= key_q;
			out_min_q    <= pend_min_q;
			out_max_q    <= pend_max_q;
			out_tick_q   <= pend_tick_q;
		end
	end

	assign req.ready    = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign rsp.valid    = out_vld_q;
	assign rsp.status   = out_status_q;
	assign rsp.known    = out_known_q;
	assign rsp.key_out  = out_key_q;
	assign rsp.min_out  = out_min_q;
	assign rsp.max_out  = out_max_q;
	assign rsp.tick_out = out_tick_q;

endmodule
